[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the calibrator sequencer (gbc_ctrl).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GBC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define GBC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define GBC_ASSERT(lbl, prop)
`define GBC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[src/gbc_pkg.sv]
// ----------------------------------------------------------------------------
// gbc_pkg
// Types and constants of the gyro bias calibrator.
// ----------------------------------------------------------------------------
package gbc_pkg;

	localparam int MEAN_CHECK_INTERVAL_DEF = 64;
	localparam int BIAS_FRAC_BITS_DEF      = 8;

	localparam logic [31:0] NORM_HIGH_RESET = 32'd3221225472;
	localparam logic [31:0] TIMEOUT_RESET   = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		CFG_TARGET_TEMP = 3'd0,
		CFG_TEMP_TOL    = 3'd1,
		CFG_NORM_LOW    = 3'd2,
		CFG_NORM_HIGH   = 3'd3,
		CFG_MAX_SPREAD  = 3'd4,
		CFG_MAX_MEAN    = 3'd5,
		CFG_WINDOW      = 3'd6,
		CFG_TIMEOUT     = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_SAMPLE  = 2'd1,
		PH_DONE    = 2'd2,
		PH_TIMEOUT = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_EVAL,
		ST_LIMIT,
		ST_CHECK,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic sq;
		logic eval;
		logic limit;
		logic check;
		logic div_step;
		logic fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic final_phase;
		logic accum;
		logic go_div;
		logic div_done;
	} status_t;

endpackage

[src/gbc_ctrl.sv]
// ----------------------------------------------------------------------------
// gbc_ctrl
// Sequencer of the calibrator: steps one item through the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gbc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  gbc_pkg::status_t status,
	output gbc_pkg::cmd_t    cmd
);

	gbc_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbc_pkg::ST_IDLE:  if (in_valid) state_d = gbc_pkg::ST_SQ;
			gbc_pkg::ST_SQ:    state_d = gbc_pkg::ST_EVAL;
			gbc_pkg::ST_EVAL: begin
				if (!status.final_phase && status.accum) state_d = gbc_pkg::ST_LIMIT;
				else state_d = gbc_pkg::ST_EMIT;
			end
			gbc_pkg::ST_LIMIT: state_d = gbc_pkg::ST_CHECK;
			gbc_pkg::ST_CHECK: begin
				if (status.go_div) state_d = gbc_pkg::ST_DIV;
				else state_d = gbc_pkg::ST_EMIT;
			end
			gbc_pkg::ST_DIV:   if (status.div_done) state_d = gbc_pkg::ST_FIN;
			gbc_pkg::ST_FIN:   state_d = gbc_pkg::ST_EMIT;
			gbc_pkg::ST_EMIT:  if (slot_free) state_d = gbc_pkg::ST_IDLE;
			default:           state_d = gbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == gbc_pkg::ST_IDLE) && in_valid;
		cmd.sq       = (state_q == gbc_pkg::ST_SQ);
		cmd.eval     = (state_q == gbc_pkg::ST_EVAL) && !status.final_phase;
		cmd.limit    = (state_q == gbc_pkg::ST_LIMIT);
		cmd.check    = (state_q == gbc_pkg::ST_CHECK);
		cmd.div_step = (state_q == gbc_pkg::ST_DIV) && !status.div_done;
		cmd.fin      = (state_q == gbc_pkg::ST_FIN);
		cmd.emit     = (state_q == gbc_pkg::ST_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == gbc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	`GBC_ASSERT(a_cmd_onehot, $onehot0(cmd))
	`GBC_ASSERT_IMP(a_accept_seq, in_valid && in_ready, ##1 state_q == gbc_pkg::ST_SQ)
	`GBC_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 out_valid)
	`GBC_ASSERT_IMP(a_emit_free, cmd.emit, !out_valid_q || out_ready)

endmodule

[src/gbc_datapath.sv]
// ----------------------------------------------------------------------------
// gbc_datapath
// Registers, window accumulators, checks and bias divider of the calibrator.
// ----------------------------------------------------------------------------
module gbc_datapath #(
	parameter int MEAN_CHECK_INTERVAL = gbc_pkg::MEAN_CHECK_INTERVAL_DEF,
	parameter int BIAS_FRAC_BITS      = gbc_pkg::BIAS_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  gbc_pkg::cmd_t      cmd,
	output gbc_pkg::status_t   status,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] temperature,
	input  logic [31:0]        tick,
	output logic [1:0]         phase,
	output logic signed [23:0] bias_x,
	output logic signed [23:0] bias_y,
	output logic signed [23:0] bias_z,
	output logic [15:0]        spread_x,
	output logic [15:0]        spread_y,
	output logic [15:0]        spread_z,
	output logic [31:0]        sample_count,
	output logic [31:0]        restart_count,
	output logic [31:0]        elapsed_ticks,
	output logic signed [15:0] last_temperature,
	output logic               bias_valid
);

	localparam int DW    = 48 + BIAS_FRAC_BITS;
	localparam int CNT_W = $clog2(DW + 1);
	localparam int MOD_W = (MEAN_CHECK_INTERVAL > 1) ? $clog2(MEAN_CHECK_INTERVAL) : 1;
	localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(MEAN_CHECK_INTERVAL - 1);
	localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};
	localparam logic [DW-1:0] BIAS_POS_LIM = DW'(24'h7F_FFFF);
	localparam logic [DW-1:0] BIAS_NEG_LIM = DW'(24'h80_0000);

	// configuration
	logic signed [15:0] target_q;
	logic [15:0]        tol_q;
	logic [31:0]        norm_low_q;
	logic [31:0]        norm_high_q;
	logic [15:0]        max_spread_q;
	logic [15:0]        max_mean_q;
	logic [31:0]        window_q;
	logic [31:0]        timeout_q;

	// state
	gbc_pkg::phase_t    phase_q;
	logic signed [47:0] sum_q [3];
	logic signed [15:0] min_q [3];
	logic signed [15:0] max_q [3];
	logic [31:0]        count_q;
	logic [MOD_W-1:0]   mod_q;
	logic [31:0]        restarts_q;
	logic [31:0]        wstart_q;
	logic [31:0]        ready_q;
	logic [31:0]        last_q;
	logic signed [15:0] temp_q;
	logic signed [23:0] bias_q [3];
	logic [15:0]        spread_q [3];
	logic               valid_q;

	// latched item
	logic signed [15:0] g_q [3];
	logic signed [15:0] a_q [3];
	logic signed [15:0] tin_q;
	logic [31:0]        tick_q;

	logic [31:0]        sq_s1 [3];
	logic               tbad_s1;
	logic [47:0]        lim_s2;
	logic               sbad_s2;
	logic               wdone_s2;

	// divider
	logic [DW-1:0]      dq_q [3];
	logic [31:0]        rem_q [3];
	logic [CNT_W-1:0]   dcnt_q;

	logic               phase0;
	logic [31:0]        rt;
	logic               tmo;
	logic [33:0]        nsq;
	logic               abad;
	logic               do_restart;
	logic               eval_accum;
	logic               mbad;
	logic               chk_restart;
	logic               go_div;
	logic [47:0]        mag [3];
	logic signed [48:0] sum_ext [3];
	logic signed [47:0] sum_new [3];
	logic signed [16:0] tdiff;
	logic [16:0]        tmag;
	logic signed [16:0] spr [3];
	logic [32:0]        trial [3];

	always_comb begin
		phase0 = (phase_q == gbc_pkg::PH_WAIT);
		rt     = phase0 ? tick_q : ready_q;
		tmo    = (tick_q - rt) > timeout_q;
		nsq    = {2'b00, sq_s1[0]} + {2'b00, sq_s1[1]} + {2'b00, sq_s1[2]};
		abad   = (nsq < {2'b00, norm_low_q}) || (nsq > {2'b00, norm_high_q});
		eval_accum = !tbad_s1 && !tmo && !abad;
		tdiff  = 17'(tin_q) - 17'(target_q);
		tmag   = tdiff[16] ? 17'(-tdiff) : 17'(tdiff);
		mbad   = 1'b0;
		for (int a = 0; a < 3; a++) begin
			mag[a]     = sum_q[a][47] ? 48'(-sum_q[a]) : 48'(sum_q[a]);
			sum_ext[a] = 49'(sum_q[a]) + 49'(g_q[a]);
			if (sum_ext[a] > 49'(SUM_MAX)) sum_new[a] = SUM_MAX;
			else if (sum_ext[a] < 49'(SUM_MIN)) sum_new[a] = SUM_MIN;
			else sum_new[a] = sum_ext[a][47:0];
			spr[a]     = 17'(max_q[a]) - 17'(min_q[a]);
			trial[a]   = {rem_q[a], dq_q[a][DW-1]};
			if (mag[a] > lim_s2) mbad = 1'b1;
		end
		chk_restart = sbad_s2 || (mbad && ((mod_q == '0) || wdone_s2));
		go_div      = !chk_restart && wdone_s2;
		do_restart  = 1'b0;
		if (cmd.eval) begin
			priority if (tbad_s1) do_restart = !phase0 || (count_q != '0);
			else if (phase0) do_restart = 1'b1;
			else if (!tmo && abad) do_restart = 1'b1;
		end
		if (cmd.check && chk_restart) do_restart = 1'b1;
	end

	assign status.final_phase = phase_q[1];
	assign status.accum       = eval_accum;
	assign status.go_div      = go_div;
	assign status.div_done    = (dcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			tol_q        <= '0;
			norm_low_q   <= '0;
			norm_high_q  <= gbc_pkg::NORM_HIGH_RESET;
			max_spread_q <= '0;
			max_mean_q   <= '0;
			window_q     <= '0;
			timeout_q    <= gbc_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (gbc_pkg::cfg_idx_t'(cfg_index))
				gbc_pkg::CFG_TARGET_TEMP: target_q     <= cfg_data[15:0];
				gbc_pkg::CFG_TEMP_TOL:    tol_q        <= cfg_data[15:0];
				gbc_pkg::CFG_NORM_LOW:    norm_low_q   <= cfg_data;
				gbc_pkg::CFG_NORM_HIGH:   norm_high_q  <= cfg_data;
				gbc_pkg::CFG_MAX_SPREAD:  max_spread_q <= cfg_data[15:0];
				gbc_pkg::CFG_MAX_MEAN:    max_mean_q   <= cfg_data[15:0];
				gbc_pkg::CFG_WINDOW:      window_q     <= cfg_data;
				gbc_pkg::CFG_TIMEOUT:     timeout_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			g_q[0] <= gyro_x;
			g_q[1] <= gyro_y;
			g_q[2] <= gyro_z;
			a_q[0] <= accel_x;
			a_q[1] <= accel_y;
			a_q[2] <= accel_z;
			tin_q  <= temperature;
			tick_q <= tick;
		end
		if (cmd.sq) begin
			for (int a = 0; a < 3; a++) sq_s1[a] <= 32'(a_q[a] * a_q[a]);
			tbad_s1 <= tmag > {1'b0, tol_q};
		end
		if (cmd.limit) begin
			lim_s2   <= 48'(max_mean_q) * 48'(count_q);
			sbad_s2  <= (17'(spr[0]) > {1'b0, max_spread_q}) ||
			            (17'(spr[1]) > {1'b0, max_spread_q}) ||
			            (17'(spr[2]) > {1'b0, max_spread_q});
			wdone_s2 <= (tick_q - wstart_q) >= window_q;
		end
		if (cmd.check && go_div) begin
			for (int a = 0; a < 3; a++) begin
				dq_q[a]  <= DW'(mag[a]) << BIAS_FRAC_BITS;
				rem_q[a] <= '0;
			end
		end
		if (cmd.div_step) begin
			for (int a = 0; a < 3; a++) begin
				if (trial[a] >= {1'b0, count_q}) begin
					rem_q[a] <= 32'(trial[a] - {1'b0, count_q});
					dq_q[a]  <= {dq_q[a][DW-2:0], 1'b1};
				end else begin
					rem_q[a] <= trial[a][31:0];
					dq_q[a]  <= {dq_q[a][DW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.check && go_div) begin
			dcnt_q <= CNT_W'(DW);
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= gbc_pkg::PH_WAIT;
			count_q    <= '0;
			mod_q      <= '0;
			restarts_q <= '0;
			wstart_q   <= '0;
			ready_q    <= '0;
			last_q     <= '0;
			temp_q     <= '0;
			valid_q    <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a]    <= '0;
				min_q[a]    <= '0;
				max_q[a]    <= '0;
				bias_q[a]   <= '0;
				spread_q[a] <= '0;
			end
		end else begin
			if (do_restart) begin
				if (count_q != '0) restarts_q <= restarts_q + 1'b1;
				count_q  <= '0;
				mod_q    <= '0;
				wstart_q <= tick_q;
				last_q   <= tick_q;
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= '0;
					min_q[a] <= '0;
					max_q[a] <= '0;
				end
			end
			if (cmd.eval) begin
				last_q <= tick_q;
				temp_q <= tin_q;
				if (tbad_s1) begin
					phase_q <= gbc_pkg::PH_WAIT;
					ready_q <= tick_q;
				end else begin
					if (phase0) begin
						phase_q <= gbc_pkg::PH_SAMPLE;
						ready_q <= tick_q;
					end
					if (tmo) begin
						phase_q <= gbc_pkg::PH_TIMEOUT;
						valid_q <= 1'b0;
					end else if (!abad) begin
						for (int a = 0; a < 3; a++) begin
							sum_q[a] <= sum_new[a];
							if (count_q == '0) begin
								min_q[a] <= g_q[a];
								max_q[a] <= g_q[a];
							end else begin
								if (g_q[a] < min_q[a]) min_q[a] <= g_q[a];
								if (g_q[a] > max_q[a]) max_q[a] <= g_q[a];
							end
						end
						if (count_q != 32'hFFFF_FFFF) begin
							count_q <= count_q + 1'b1;
							mod_q   <= (mod_q == MOD_LAST) ? '0 : MOD_W'(mod_q + 1'b1);
						end
					end
				end
			end
			if (cmd.fin) begin
				for (int a = 0; a < 3; a++) begin
					if (sum_q[a][47]) begin
						if (dq_q[a] > BIAS_NEG_LIM) bias_q[a] <= 24'sh80_0000;
						else bias_q[a] <= 24'(-dq_q[a][23:0]);
					end else begin
						if (dq_q[a] > BIAS_POS_LIM) bias_q[a] <= 24'sh7F_FFFF;
						else bias_q[a] <= dq_q[a][23:0];
					end
					spread_q[a] <= spr[a][15:0];
				end
				valid_q <= 1'b1;
				phase_q <= gbc_pkg::PH_DONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			phase            <= phase_q;
			bias_x           <= bias_q[0];
			bias_y           <= bias_q[1];
			bias_z           <= bias_q[2];
			spread_x         <= spread_q[0];
			spread_y         <= spread_q[1];
			spread_z         <= spread_q[2];
			sample_count     <= count_q;
			restart_count    <= restarts_q;
			elapsed_ticks    <= last_q - ready_q;
			last_temperature <= temp_q;
			bias_valid       <= valid_q;
		end
	end

endmodule

[src/gyro_bias_calibrator_core.sv]
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_core
// Static gyro bias calibration over a temperature-gated stationary window.
// ----------------------------------------------------------------------------
// An item that is not accumulated passes through the SQ, EVAL and EMIT states;
// one that is, through SQ, EVAL, LIMIT, CHECK and EMIT. One item at a time: a
// new item is taken only in IDLE. A window that finalizes adds the bit-serial
// divider (one quotient bit per cycle, three axes in parallel).
// A result held in the output register delays the next emit and the next accept.
// Reset: asynchronous, active low; clears control, config and calibration state.
module gyro_bias_calibrator_core #(
	parameter int MEAN_CHECK_INTERVAL = gbc_pkg::MEAN_CHECK_INTERVAL_DEF,
	parameter int BIAS_FRAC_BITS      = gbc_pkg::BIAS_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] temperature,
	input  logic [31:0]        tick,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         phase,
	output logic signed [23:0] bias_x,
	output logic signed [23:0] bias_y,
	output logic signed [23:0] bias_z,
	output logic [15:0]        spread_x,
	output logic [15:0]        spread_y,
	output logic [15:0]        spread_z,
	output logic [31:0]        sample_count,
	output logic [31:0]        restart_count,
	output logic [31:0]        elapsed_ticks,
	output logic signed [15:0] last_temperature,
	output logic               bias_valid
);

	gbc_pkg::cmd_t    cmd;
	gbc_pkg::status_t status;

	gbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	gbc_datapath #(
		.MEAN_CHECK_INTERVAL (MEAN_CHECK_INTERVAL),
		.BIAS_FRAC_BITS      (BIAS_FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.status           (status),
		.gyro_x           (gyro_x),
		.gyro_y           (gyro_y),
		.gyro_z           (gyro_z),
		.accel_x          (accel_x),
		.accel_y          (accel_y),
		.accel_z          (accel_z),
		.temperature      (temperature),
		.tick             (tick),
		.phase            (phase),
		.bias_x           (bias_x),
		.bias_y           (bias_y),
		.bias_z           (bias_z),
		.spread_x         (spread_x),
		.spread_y         (spread_y),
		.spread_z         (spread_z),
		.sample_count     (sample_count),
		.restart_count    (restart_count),
		.elapsed_ticks    (elapsed_ticks),
		.last_temperature (last_temperature),
		.bias_valid       (bias_valid)
	);

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gyro_bias_calibrator_core. Walks a short table of
// IMU samples, then several configuration phases of random stationary, noisy and
// arbitrary samples. Each status item is compared against an in-bench model of
// the calibrator or a fixed table value, random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [15:0] gx, gy, gz, ax, ay, az, temp;
		logic [31:0]        tick;
	} imu_sample_t;

	typedef struct {
		gbc_pkg::phase_t    ph;
		logic signed [23:0] bx, by, bz;
		logic [15:0]        sx, sy, sz;
		logic [31:0]        cnt, rst, elap;
		logic signed [15:0] temp;
		logic               vld;
	} cal_status_t;

	typedef struct {
		imu_sample_t s;
		bit          typed;
		cal_status_t want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
	logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [15:0] temperature = '0;
	logic [31:0] tick = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] phase;
	logic signed [23:0] bias_x, bias_y, bias_z;
	logic [15:0] spread_x, spread_y, spread_z;
	logic [31:0] sample_count, restart_count, elapsed_ticks;
	logic signed [15:0] last_temperature;
	logic bias_valid;

	gyro_bias_calibrator_core dut (.*);

	always #10 clk = ~clk;

	// model configuration
	logic signed [15:0] m_target;
	logic [15:0] m_tol, m_spread_lim, m_mean_lim;
	logic [31:0] m_norm_lo, m_norm_hi, m_window, m_timeout;
	// model state
	gbc_pkg::phase_t m_ph;
	longint m_sum[3];
	int m_min[3], m_max[3];
	logic [31:0] m_cnt, m_rst, m_wstart, m_ready, m_last;
	logic signed [15:0] m_temp;
	logic signed [23:0] m_bias[3];
	logic [15:0] m_spr[3];
	logic m_vld;

	cal_status_t status_q[$];
	int errors = 0;
	int cycles = 0;
	bit idling = 1'b1;
	bit long_hold = 1'b0;
	int hold_left = 0;
	logic [31:0] tick_now = 32'd0;

	task automatic window_restart(input logic [31:0] t);
		if (m_cnt != 0) m_rst++;
		for (int a = 0; a < 3; a++) begin
			m_sum[a] = 0;
			m_min[a] = 0;
			m_max[a] = 0;
		end
		m_cnt = 0;
		m_wstart = t;
		m_last = t;
	endtask

	function automatic bit mean_high();
		longint unsigned lim;
		longint unsigned mag;
		lim = longint'(m_mean_lim) * longint'(m_cnt);
		for (int a = 0; a < 3; a++) begin
			mag = m_sum[a] < 0 ? -m_sum[a] : m_sum[a];
			if (mag > lim) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit spread_high();
		for (int a = 0; a < 3; a++)
			if (32'(m_max[a] - m_min[a]) > {16'd0, m_spread_lim}) return 1'b1;
		return 1'b0;
	endfunction

	task automatic window_close();
		longint unsigned q;
		longint b;
		if (m_cnt == 0 || mean_high() || spread_high()) begin
			window_restart(m_last);
			return;
		end
		for (int a = 0; a < 3; a++) begin
			q = (longint'(m_sum[a] < 0 ? -m_sum[a] : m_sum[a]) << 8) / longint'(m_cnt);
			if (q > (64'd1 << 40)) q = 64'd1 << 40;
			b = m_sum[a] < 0 ? -longint'(q) : longint'(q);
			if (b > 8388607) b = 8388607;
			if (b < -8388608) b = -8388608;
			m_bias[a] = b[23:0];
			m_spr[a] = 16'(m_max[a] - m_min[a]);
		end
		m_vld = 1'b1;
		m_ph = gbc_pkg::PH_DONE;
	endtask

	task automatic window_add(input int g[3], input logic [31:0] t);
		for (int a = 0; a < 3; a++) begin
			if (m_cnt == 0) begin
				m_min[a] = g[a];
				m_max[a] = g[a];
			end else begin
				if (g[a] < m_min[a]) m_min[a] = g[a];
				if (g[a] > m_max[a]) m_max[a] = g[a];
			end
			m_sum[a] += g[a];
			if (m_sum[a] > 64'sh7FFF_FFFF_FFFF) m_sum[a] = 64'sh7FFF_FFFF_FFFF;
			if (m_sum[a] < -64'sh8000_0000_0000) m_sum[a] = -64'sh8000_0000_0000;
		end
		if (m_cnt != 32'hFFFF_FFFF) m_cnt++;
		if (spread_high()) begin
			window_restart(t);
			return;
		end
		if (m_cnt % gbc_pkg::MEAN_CHECK_INTERVAL_DEF == 0 && mean_high()) begin
			window_restart(t);
			return;
		end
		if (32'(t - m_wstart) >= m_window) window_close();
	endtask

	function automatic cal_status_t status_now();
		cal_status_t r;
		r.ph = m_ph;
		r.bx = m_bias[0];
		r.by = m_bias[1];
		r.bz = m_bias[2];
		r.sx = m_spr[0];
		r.sy = m_spr[1];
		r.sz = m_spr[2];
		r.cnt = m_cnt;
		r.rst = m_rst;
		r.elap = m_last - m_ready;
		r.temp = m_temp;
		r.vld = m_vld;
		return r;
	endfunction

	task automatic calibrate_step(input imu_sample_t s, output cal_status_t r);
		int g[3];
		int d;
		longint nsq;
		if (m_ph == gbc_pkg::PH_DONE || m_ph == gbc_pkg::PH_TIMEOUT) begin
			r = status_now();
			return;
		end
		g[0] = int'(s.gx);
		g[1] = int'(s.gy);
		g[2] = int'(s.gz);
		m_last = s.tick;
		m_temp = s.temp;
		d = int'(s.temp) - int'(m_target);
		if (d < 0) d = -d;
		if (d > int'(m_tol)) begin
			if (m_ph != gbc_pkg::PH_WAIT || m_cnt != 0) window_restart(s.tick);
			m_ph = gbc_pkg::PH_WAIT;
			m_ready = s.tick;
			r = status_now();
			return;
		end
		if (m_ph == gbc_pkg::PH_WAIT) begin
			m_ph = gbc_pkg::PH_SAMPLE;
			m_ready = s.tick;
			window_restart(s.tick);
		end
		if (32'(s.tick - m_ready) > m_timeout) begin
			m_ph = gbc_pkg::PH_TIMEOUT;
			m_vld = 1'b0;
			r = status_now();
			return;
		end
		nsq = longint'(s.ax) * s.ax + longint'(s.ay) * s.ay + longint'(s.az) * s.az;
		if (nsq < longint'(m_norm_lo) || nsq > longint'(m_norm_hi)) begin
			window_restart(s.tick);
			r = status_now();
			return;
		end
		window_add(g, s.tick);
		r = status_now();
	endtask

	task automatic model_reset();
		m_target = 0;
		m_tol = 0;
		m_norm_lo = 0;
		m_norm_hi = gbc_pkg::NORM_HIGH_RESET;
		m_spread_lim = 0;
		m_mean_lim = 0;
		m_window = 0;
		m_timeout = gbc_pkg::TIMEOUT_RESET;
		m_ph = gbc_pkg::PH_WAIT;
		for (int a = 0; a < 3; a++) begin
			m_sum[a] = 0;
			m_min[a] = 0;
			m_max[a] = 0;
			m_bias[a] = 0;
			m_spr[a] = 0;
		end
		m_cnt = 0;
		m_rst = 0;
		m_wstart = 0;
		m_ready = 0;
		m_last = 0;
		m_temp = 0;
		m_vld = 1'b0;
	endtask

	// write all registers back to back, starting at a rising edge
	task automatic load_settings(input logic [31:0] v[8]);
		gbc_pkg::cfg_idx_t idx;
		for (int i = 0; i < 8; i++) begin
			idx = gbc_pkg::cfg_idx_t'(i);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= v[i];
			case (idx)
				gbc_pkg::CFG_TARGET_TEMP: m_target = v[i][15:0];
				gbc_pkg::CFG_TEMP_TOL:    m_tol = v[i][15:0];
				gbc_pkg::CFG_NORM_LOW:    m_norm_lo = v[i];
				gbc_pkg::CFG_NORM_HIGH:   m_norm_hi = v[i];
				gbc_pkg::CFG_MAX_SPREAD:  m_spread_lim = v[i][15:0];
				gbc_pkg::CFG_MAX_MEAN:    m_mean_lim = v[i][15:0];
				gbc_pkg::CFG_WINDOW:      m_window = v[i];
				gbc_pkg::CFG_TIMEOUT:     m_timeout = v[i];
				default: ;
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	// called at a rising edge; returns at the edge that accepts the item, or after a random idle that follows it
	task automatic send_item(input imu_sample_t s, input bit typed, input cal_status_t want);
		cal_status_t r;
		in_valid <= 1'b1;
		gyro_x <= s.gx;
		gyro_y <= s.gy;
		gyro_z <= s.gz;
		accel_x <= s.ax;
		accel_y <= s.ay;
		accel_z <= s.az;
		temperature <= s.temp;
		tick <= s.tick;
		do @(posedge clk); while (!in_ready);
		calibrate_step(s, r);
		status_q.push_back(typed ? want : r);
		if (idling && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] jitter(int base, int amp);
		return 16'(base + $urandom_range(0, 2 * amp) - amp);
	endfunction

	// full: any value at all; otherwise a mostly stationary sensor with noise
	task automatic make_sample(input bit full, input int tgt, input int gb[3],
			output imu_sample_t s);
		int r;
		if (full) begin
			s.gx = 16'($urandom);
			s.gy = 16'($urandom);
			s.gz = 16'($urandom);
			s.ax = 16'($urandom);
			s.ay = 16'($urandom);
			s.az = 16'($urandom);
			s.temp = 16'($urandom);
			tick_now += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 5000);
		end else begin
			r = $urandom_range(0, 99);
			s.gx = jitter(gb[0], 20);
			s.gy = jitter(gb[1], 20);
			s.gz = jitter(gb[2], 20);
			s.ax = jitter(0, 200);
			s.ay = jitter(0, 200);
			s.az = jitter(16384, 300);
			s.temp = jitter(tgt, 40);
			if (r < 3) s.temp = jitter(tgt + 3000, 100);
			else if (r < 6) s.az = jitter(0, 100);
			else if (r < 8) s.gx = jitter(gb[0] + 1000, 50);
			tick_now += $urandom_range(1, 10);
		end
		s.tick = tick_now;
	endtask

	task automatic run_phase(input int n, input bit full, input int tgt, input int gb[3],
			input int pause_at);
		imu_sample_t s;
		cal_status_t none;
		none = status_now();
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (status_q.size() != 0);
			end
			make_sample(full, tgt, gb, s);
			send_item(s, 1'b0, none);
		end
		drain();
	endtask

	function automatic table_row_t row(int gx, int gy, int gz, int ax, int ay, int az,
			int t, logic [31:0] tk);
		table_row_t w;
		w.s.gx = 16'(gx);
		w.s.gy = 16'(gy);
		w.s.gz = 16'(gz);
		w.s.ax = 16'(ax);
		w.s.ay = 16'(ay);
		w.s.az = 16'(az);
		w.s.temp = 16'(t);
		w.s.tick = tk;
		w.typed = 1'b0;
		w.want = '{gbc_pkg::PH_WAIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0};
		return w;
	endfunction

	task automatic check_field(input string nm, input longint e, input longint a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		cal_status_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (out_valid && out_ready) begin
			if (status_q.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual phase %0d",
					$time, phase);
				errors++;
			end else begin
				e = status_q.pop_front();
				check_field("phase", e.ph, phase);
				check_field("bias_x", e.bx, bias_x);
				check_field("bias_y", e.by, bias_y);
				check_field("bias_z", e.bz, bias_z);
				check_field("spread_x", e.sx, spread_x);
				check_field("spread_y", e.sy, spread_y);
				check_field("spread_z", e.sz, spread_z);
				check_field("sample_count", e.cnt, sample_count);
				check_field("restart_count", e.rst, restart_count);
				check_field("elapsed_ticks", e.elap, elapsed_ticks);
				check_field("last_temperature", e.temp, last_temperature);
				check_field("bias_valid", e.vld, bias_valid);
			end
		end
		if (long_hold) begin
			long_hold = 1'b0;
			hold_left = 400;
		end else if (hold_left == 0 && idling && $urandom_range(0, 5) == 0)
			hold_left = $urandom_range(1, 10);
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	initial begin
		table_row_t rows[$];
		table_row_t w;
		int gb[3];
		logic [31:0] v[8];
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		w = row(0, 0, 0, 0, 0, 0, 1000, 5);
		w.typed = 1'b1;
		w.want = '{gbc_pkg::PH_WAIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'sd1000, 1'b0};
		rows.push_back(w);
		w = row(5, -5, 7, 0, 0, 0, 0, 10);
		w.typed = 1'b1;
		w.want = '{gbc_pkg::PH_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1'b0};
		rows.push_back(w);
		rows.push_back(row(32767, -32768, 1, -32768, -32768, -32768, 0, 11));
		rows.push_back(row(-32768, 32767, -1, 32767, 32767, 32767, 0, 12));
		rows.push_back(row(1, 2, 3, 32767, -32768, 0, -32768, 32'hFFFF_FFFF));
		rows.push_back(row(-1, -2, -3, 0, 0, 0, 32767, 0));
		rows.push_back(row(100, 0, -100, 0, 0, 16384, 0, 32'h8000_0000));
		rows.push_back(row(-7, 7, 0, 100, 200, 300, 0, 32'h8000_0003));
		foreach (rows[i]) send_item(rows[i].s, rows[i].typed, rows[i].want);
		drain();

		// cold: temperature rarely in band, register extremes
		v = '{32'hFFFF_8000, 32'd0, gbc_pkg::NORM_HIGH_RESET, 32'd0, 32'd0, 32'd0, 32'd0,
			32'd0};
		load_settings(v);
		gb = '{0, 0, 0};
		run_phase(150, 1'b1, 0, gb, -1);

		// steady sensor, window never closes; long output hold and one pause
		v = '{32'd250, 32'd50, 32'd200000000, 32'd350000000, 32'd200, 32'd3,
			32'hFFFF_FFFF, 32'hFFFF_FFFF};
		load_settings(v);
		long_hold = 1'b1;
		gb = '{1, -2, 0};
		run_phase(500, 1'b0, 250, gb, 250);

		// short windows that close and mostly fail the mean check
		v = '{32'hFFFF_FF00, 32'd50, 32'd200000000, 32'd350000000, 32'd100, 32'd2,
			32'd40, 32'd1000000};
		load_settings(v);
		gb = '{2, -1, 3};
		run_phase(400, 1'b0, -256, gb, -1);

		// wide open limits with any sample
		v = '{32'd0, 32'd65535, 32'd0, gbc_pkg::NORM_HIGH_RESET, 32'd65535, 32'd32768,
			32'hFFFF_FFFF, 32'hFFFF_FFFF};
		load_settings(v);
		run_phase(250, 1'b1, 0, gb, -1);

		// completion, then held status; no idling here
		v = '{32'd250, 32'd50, 32'd200000000, 32'd350000000, 32'd65535, 32'd32768,
			32'd300, 32'hFFFF_FFFF};
		load_settings(v);
		idling = 1'b0;
		gb = '{1234, -777, 55};
		run_phase(50, 1'b0, 250, gb, -1);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
